// ===== src/dlsb_pkg.sv =====
// Shared types, codes and reset values for the dual LED status blinker.
package dlsb_pkg;

   localparam int TimerW = 16;
   localparam int CsrIdxW = 3;
   localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

   // Input item action codes
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_CONN  = 2'd1,
      ACT_POWER = 2'd2
   } action_type;

   // Connection LED modes
   typedef enum logic [2:0] {
      CONN_IDLE      = 3'd0,
      CONN_WIRED     = 3'd1,
      CONN_SUCCESS   = 3'd2,
      CONN_PAIRING   = 3'd3,
      CONN_RECONNECT = 3'd4
   } conn_mode_type;

   // Power LED modes
   typedef enum logic [1:0] {
      PWR_IDLE     = 2'd0,
      PWR_CHARGING = 2'd1,
      PWR_CHARGED  = 2'd2,
      PWR_LOW_BATT = 2'd3
   } power_mode_type;

   // Register indexes on the csr port
   localparam logic [CsrIdxW-1:0] REG_PAIRING_ON    = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_PAIRING_OFF   = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_RECONNECT_ON  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_RECONNECT_OFF = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_LOW_BATT_ON   = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_LOW_BATT_OFF  = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_SOLID_HOLD    = 3'd6;

   // Register reset values in ms
   localparam logic [TimerW-1:0] RstPairingOn    = 16'd100;
   localparam logic [TimerW-1:0] RstPairingOff   = 16'd233;
   localparam logic [TimerW-1:0] RstReconnectOn  = 16'd200;
   localparam logic [TimerW-1:0] RstReconnectOff = 16'd800;
   localparam logic [TimerW-1:0] RstLowBattOn    = 16'd200;
   localparam logic [TimerW-1:0] RstLowBattOff   = 16'd2800;
   localparam logic [TimerW-1:0] RstSolidHold    = 16'd2000;

   typedef struct packed {
      logic [TimerW-1:0] pairing_on;
      logic [TimerW-1:0] pairing_off;
      logic [TimerW-1:0] reconnect_on;
      logic [TimerW-1:0] reconnect_off;
      logic [TimerW-1:0] low_batt_on;
      logic [TimerW-1:0] low_batt_off;
      logic [TimerW-1:0] solid_hold;
   } cfg_type;

   typedef struct packed {
      conn_mode_type     mode;
      logic [TimerW-1:0] elapsed;
      logic              lit;
   } conn_state_type;

   typedef struct packed {
      power_mode_type    mode;
      logic [TimerW-1:0] elapsed;
      logic              lit;
   } power_state_type;

endpackage

// ===== src/dlsb_update.sv =====
// Next-state logic for both LEDs from one input beat.
module dlsb_update (
   input  dlsb_pkg::cfg_type         cfg,
   input  dlsb_pkg::conn_state_type  conn_cur,
   input  dlsb_pkg::power_state_type power_cur,
   input  logic [1:0]                action,
   input  logic [2:0]                mode_value,
   output dlsb_pkg::conn_state_type  conn_nxt,
   output dlsb_pkg::power_state_type power_nxt
);
   import dlsb_pkg::*;

   typedef struct packed {
      logic              lit;
      logic [TimerW-1:0] elapsed;
   } blink_type;

   // saturating ms counter
   function automatic logic [TimerW-1:0] advance(input logic [TimerW-1:0] t);
      return (t == TimerMax) ? t : t + 1'b1;
   endfunction

   // toggle when the current phase has run its time
   function automatic blink_type blink(input logic lit, input logic [TimerW-1:0] elapsed,
                                       input logic [TimerW-1:0] on_ms,
                                       input logic [TimerW-1:0] off_ms);
      blink_type r;
      r.lit = lit;
      r.elapsed = elapsed;
      if (lit && elapsed >= on_ms) begin
         r.lit = 1'b0;
         r.elapsed = '0;
      end else if (!lit && elapsed >= off_ms) begin
         r.lit = 1'b1;
         r.elapsed = '0;
      end
      return r;
   endfunction

   logic [TimerW-1:0] conn_adv;
   logic [TimerW-1:0] power_adv;
   blink_type         conn_blink;
   blink_type         power_blink;

   assign conn_adv  = advance(conn_cur.elapsed);
   assign power_adv = advance(power_cur.elapsed);

   // blink candidates for the current blinking mode
   always_comb begin
      if (conn_cur.mode == CONN_RECONNECT) begin
         conn_blink = blink(conn_cur.lit, conn_adv, cfg.reconnect_on, cfg.reconnect_off);
      end else begin
         conn_blink = blink(conn_cur.lit, conn_adv, cfg.pairing_on, cfg.pairing_off);
      end
      power_blink = blink(power_cur.lit, power_adv, cfg.low_batt_on, cfg.low_batt_off);
   end

   always_comb begin
      conn_nxt  = conn_cur;
      power_nxt = power_cur;
      case (action)
         ACT_TICK: begin
            conn_nxt.elapsed  = conn_adv;
            power_nxt.elapsed = power_adv;
            case (conn_cur.mode)
               CONN_WIRED, CONN_SUCCESS: begin
                  if (conn_adv >= cfg.solid_hold) begin
                     conn_nxt.lit  = 1'b0;
                     conn_nxt.mode = CONN_IDLE;
                  end
               end
               CONN_PAIRING, CONN_RECONNECT: begin
                  conn_nxt.lit     = conn_blink.lit;
                  conn_nxt.elapsed = conn_blink.elapsed;
               end
               default: ;
            endcase
            if (power_cur.mode == PWR_LOW_BATT) begin
               power_nxt.lit     = power_blink.lit;
               power_nxt.elapsed = power_blink.elapsed;
            end
         end
         ACT_CONN: begin
            // unknown codes and a repeat of the current mode are ignored
            if (mode_value <= 3'(CONN_RECONNECT) && mode_value != conn_cur.mode) begin
               conn_nxt.mode    = conn_mode_type'(mode_value);
               conn_nxt.elapsed = '0;
               conn_nxt.lit     = (mode_value != 3'(CONN_IDLE));
            end
         end
         ACT_POWER: begin
            if (mode_value[2] == 1'b0 && mode_value[1:0] != power_cur.mode) begin
               power_nxt.mode    = power_mode_type'(mode_value[1:0]);
               power_nxt.elapsed = '0;
               power_nxt.lit     = (mode_value[1:0] == PWR_CHARGING) ||
                                   (mode_value[1:0] == PWR_LOW_BATT);
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== src/dual_led_status_blinker_unit.sv =====
// Latency: a result beat is valid the cycle after its input beat is accepted.
// Throughput: one item per cycle unless a result beat stalls; the LED state registers update in one pass.
// The output register frees when its beat is taken, so a beat may enter as one leaves.
// Reset (synchronous, active high): both LEDs dark and idle, timers cleared,
// timing registers back to their defaults, no result pending.
// Top level: csr bank, LED state registers and the result register.
module dual_led_status_blinker_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_action,
   input  logic [2:0]                   req_mode_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_conn_lit,
   output logic                         rsp_power_lit,
   output logic [2:0]                   rsp_conn_mode_now,
   output logic [1:0]                   rsp_power_mode_now,
   input  logic                         csr_write_en,
   input  logic [dlsb_pkg::CsrIdxW-1:0] csr_index,
   input  logic [dlsb_pkg::TimerW-1:0]  csr_wdata
);
   import dlsb_pkg::*;

   cfg_type         cfg_ff;
   conn_state_type  conn_ff;
   conn_state_type  conn_in;
   power_state_type power_ff;
   power_state_type power_in;
   logic            rsp_valid_ff;
   logic [2:0]      conn_mode_ff;
   logic [1:0]      power_mode_ff;
   logic            conn_lit_ff;
   logic            power_lit_ff;
   logic            accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pairing_on    <= RstPairingOn;
         cfg_ff.pairing_off   <= RstPairingOff;
         cfg_ff.reconnect_on  <= RstReconnectOn;
         cfg_ff.reconnect_off <= RstReconnectOff;
         cfg_ff.low_batt_on   <= RstLowBattOn;
         cfg_ff.low_batt_off  <= RstLowBattOff;
         cfg_ff.solid_hold    <= RstSolidHold;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_PAIRING_ON:    cfg_ff.pairing_on    <= csr_wdata;
            REG_PAIRING_OFF:   cfg_ff.pairing_off   <= csr_wdata;
            REG_RECONNECT_ON:  cfg_ff.reconnect_on  <= csr_wdata;
            REG_RECONNECT_OFF: cfg_ff.reconnect_off <= csr_wdata;
            REG_LOW_BATT_ON:   cfg_ff.low_batt_on   <= csr_wdata;
            REG_LOW_BATT_OFF:  cfg_ff.low_batt_off  <= csr_wdata;
            REG_SOLID_HOLD:    cfg_ff.solid_hold    <= csr_wdata;
            default: ;
         endcase
      end
   end

   dlsb_update u_update (
      .cfg        (cfg_ff),
      .conn_cur   (conn_ff),
      .power_cur  (power_ff),
      .action     (req_action),
      .mode_value (req_mode_value),
      .conn_nxt   (conn_in),
      .power_nxt  (power_in)
   );

   // LED state advances only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff  <= '{mode: CONN_IDLE, elapsed: '0, lit: 1'b0};
         power_ff <= '{mode: PWR_IDLE, elapsed: '0, lit: 1'b0};
      end else if (accept) begin
         conn_ff  <= conn_in;
         power_ff <= power_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         conn_lit_ff   <= conn_in.lit;
         power_lit_ff  <= power_in.lit;
         conn_mode_ff  <= conn_in.mode;
         power_mode_ff <= power_in.mode;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_conn_lit       = conn_lit_ff;
   assign rsp_power_lit      = power_lit_ff;
   assign rsp_conn_mode_now  = conn_mode_ff;
   assign rsp_power_mode_now = power_mode_ff;

endmodule

// ===== src/dlsb_checker.sv =====
// Port-level checks for the dual LED status blinker, bound to the top level.
module dlsb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_conn_lit,
   input logic       rsp_power_lit,
   input logic [2:0] rsp_conn_mode_now,
   input logic [1:0] rsp_power_mode_now
);
   import dlsb_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_conn_lit, rsp_power_lit, rsp_conn_mode_now, rsp_power_mode_now}))
      else $error("stalled result beat changed");

   // input stalls only behind a stalled result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without back-pressure");

   // idle connection LED is dark, solid modes are lit
   a_conn_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_conn_mode_now == CONN_IDLE && !rsp_conn_lit) ||
         ((rsp_conn_mode_now == CONN_WIRED || rsp_conn_mode_now == CONN_SUCCESS)
            && rsp_conn_lit) ||
         rsp_conn_mode_now == CONN_PAIRING || rsp_conn_mode_now == CONN_RECONNECT)
      else $error("connection LED inconsistent with its mode");

   // power LED: charging lit, idle and charged dark
   a_power_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_power_mode_now == PWR_CHARGING && rsp_power_lit) ||
         ((rsp_power_mode_now == PWR_IDLE || rsp_power_mode_now == PWR_CHARGED)
            && !rsp_power_lit) ||
         rsp_power_mode_now == PWR_LOW_BATT)
      else $error("power LED inconsistent with its mode");

endmodule

bind dual_led_status_blinker_unit dlsb_checker u_dlsb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_conn_lit       (rsp_conn_lit),
   .rsp_power_lit      (rsp_power_lit),
   .rsp_conn_mode_now  (rsp_conn_mode_now),
   .rsp_power_mode_now (rsp_power_mode_now)
);
